>>> sv/cheapest_price_window_finder_defines.svh
// Assertion macros shared by the cheapest price window finder RTL
`ifndef CHEAPEST_PRICE_WINDOW_FINDER_DEFINES_SVH
`define CHEAPEST_PRICE_WINDOW_FINDER_DEFINES_SVH

// same-cycle implication, checked on every clk edge outside reset
`define CPWF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpwf assertion failed");

// next-cycle implication, checked on every clk edge outside reset
`define CPWF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpwf assertion failed");

`endif

>>> sv/cpwf_pkg.sv
// Types and constants of the cheapest price window finder
`default_nettype none
package cpwf_pkg;

  localparam int HOURS      = 24;
  localparam int PRICE_BITS = 32;
  localparam int HOUR_W     = 5;
  localparam int CNT_W      = $clog2(HOURS + 1);

  localparam int THREE_LAST = 2;
  localparam int SIX_LAST   = 5;

  typedef logic signed [PRICE_BITS-1:0] price_t;
  typedef logic signed [PRICE_BITS:0]   pair_t;
  typedef logic signed [PRICE_BITS+1:0] sum3_t;
  typedef logic signed [PRICE_BITS+2:0] sum6_t;
  typedef logic        [HOUR_W-1:0]     hour_t;
  typedef logic        [CNT_W-1:0]      cnt_t;

  typedef struct packed {
    price_t price;
    logic   missing;
    logic   first;
  } item_t;

  typedef struct packed {
    price_t min_price;
    price_t max_price;
    logic   have_price;
    hour_t  cheapest_hour;
    logic   cheapest_hour_valid;
    hour_t  cheapest_three_start;
    logic   cheapest_three_valid;
    hour_t  cheapest_six_start;
    logic   cheapest_six_valid;
  } result_t;

endpackage
`default_nettype wire

>>> sv/cpwf_if.sv
// Valid/ready channel interfaces for price items and results
`default_nettype none
interface cpwf_in_if;
  import cpwf_pkg::*;
  logic   valid;
  logic   ready;
  price_t price;
  logic   missing;
  logic   first;
  modport source (output valid, price, missing, first, input ready);
  modport sink (input valid, price, missing, first, output ready);
endinterface

interface cpwf_out_if;
  import cpwf_pkg::*;
  logic   valid;
  logic   ready;
  price_t min_price;
  price_t max_price;
  logic   have_price;
  hour_t  cheapest_hour;
  logic   cheapest_hour_valid;
  hour_t  cheapest_three_start;
  logic   cheapest_three_valid;
  hour_t  cheapest_six_start;
  logic   cheapest_six_valid;
  modport source (output valid, min_price, max_price, have_price, cheapest_hour,
                  cheapest_hour_valid, cheapest_three_start, cheapest_three_valid,
                  cheapest_six_start, cheapest_six_valid, input ready);
  modport sink (input valid, min_price, max_price, have_price, cheapest_hour,
                cheapest_hour_valid, cheapest_three_start, cheapest_three_valid,
                cheapest_six_start, cheapest_six_valid, output ready);
endinterface
`default_nettype wire

>>> sv/cpwf_track.sv
// Per-day tracking state: min/max, cheapest hour, cheapest 3h and 6h windows
`default_nettype none
`include "cheapest_price_window_finder_defines.svh"
module cpwf_track (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             upd,
  input  wire cpwf_pkg::item_t  item,
  output cpwf_pkg::result_t     res
);
  import cpwf_pkg::*;

  cnt_t   cnt_r, cnt_nxt;
  logic   stop_r, stop_nxt;
  logic   have_r, have_nxt;
  logic   v1_r, v1_nxt;
  logic   v3_r, v3_nxt;
  logic   v6_r, v6_nxt;
  price_t low_r, low_nxt;
  price_t high_r, high_nxt;
  price_t best1_r, best1_nxt;
  hour_t  hour1_r, hour1_nxt;
  sum3_t  best3_r, best3_nxt;
  hour_t  hour3_r, hour3_nxt;
  sum6_t  best6_r, best6_nxt;
  hour_t  hour6_r, hour6_nxt;
  price_t last_r, last_nxt;
  pair_t  pair_r, pair_nxt;
  sum3_t  hist_r [3];
  sum3_t  hist_nxt [3];

  price_t p;
  sum3_t  s3;
  sum6_t  s6;
  logic   take;
  logic   acc;

  assign p = item.price;

  always_comb begin
    // a first item clears the day before it is handled
    cnt_nxt   = item.first ? '0 : cnt_r;
    stop_nxt  = item.first ? 1'b0 : stop_r;
    have_nxt  = item.first ? 1'b0 : have_r;
    v1_nxt    = item.first ? 1'b0 : v1_r;
    v3_nxt    = item.first ? 1'b0 : v3_r;
    v6_nxt    = item.first ? 1'b0 : v6_r;
    low_nxt   = item.first ? '0 : low_r;
    high_nxt  = item.first ? '0 : high_r;
    best1_nxt = item.first ? '0 : best1_r;
    hour1_nxt = item.first ? '0 : hour1_r;
    best3_nxt = item.first ? '0 : best3_r;
    hour3_nxt = item.first ? '0 : hour3_r;
    best6_nxt = item.first ? '0 : best6_r;
    hour6_nxt = item.first ? '0 : hour6_r;
    last_nxt  = item.first ? '0 : last_r;
    pair_nxt  = item.first ? '0 : pair_r;
    for (int k = 0; k < 3; k++) begin
      hist_nxt[k] = item.first ? '0 : hist_r[k];
    end

    // window sums: s3 = r1 + r0 + p, s6 = s3 + (r4 + r3 + r2)
    s3   = sum3_t'(pair_nxt) + sum3_t'(p);
    s6   = sum6_t'(s3) + sum6_t'(hist_nxt[2]);
    take = !stop_nxt && (cnt_nxt < cnt_t'(HOURS));
    acc  = take && !item.missing;

    if (take && item.missing) begin
      stop_nxt = 1'b1;
    end

    if (acc) begin
      if (!have_nxt || p < low_nxt) begin
        low_nxt = p;
      end
      if (!have_nxt || p > high_nxt) begin
        high_nxt = p;
      end
      have_nxt = 1'b1;
      if (!v1_nxt || best1_nxt > p) begin
        best1_nxt = p;
        hour1_nxt = hour_t'(cnt_nxt);
        v1_nxt    = 1'b1;
      end
      if (cnt_nxt >= cnt_t'(THREE_LAST) && (!v3_nxt || best3_nxt > s3)) begin
        best3_nxt = s3;
        hour3_nxt = hour_t'(cnt_nxt - cnt_t'(THREE_LAST));
        v3_nxt    = 1'b1;
      end
      if (cnt_nxt >= cnt_t'(SIX_LAST) && (!v6_nxt || best6_nxt > s6)) begin
        best6_nxt = s6;
        hour6_nxt = hour_t'(cnt_nxt - cnt_t'(SIX_LAST));
        v6_nxt    = 1'b1;
      end
      hist_nxt[2] = hist_nxt[1];
      hist_nxt[1] = hist_nxt[0];
      hist_nxt[0] = s3;
      pair_nxt    = pair_t'(p) + pair_t'(last_nxt);
      last_nxt    = p;
      cnt_nxt     = cnt_nxt + cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      stop_r  <= 1'b0;
      have_r  <= 1'b0;
      v1_r    <= 1'b0;
      v3_r    <= 1'b0;
      v6_r    <= 1'b0;
      low_r   <= '0;
      high_r  <= '0;
      best1_r <= '0;
      hour1_r <= '0;
      best3_r <= '0;
      hour3_r <= '0;
      best6_r <= '0;
      hour6_r <= '0;
      last_r  <= '0;
      pair_r  <= '0;
      for (int k = 0; k < 3; k++) begin
        hist_r[k] <= '0;
      end
    end else if (upd) begin
      cnt_r   <= cnt_nxt;
      stop_r  <= stop_nxt;
      have_r  <= have_nxt;
      v1_r    <= v1_nxt;
      v3_r    <= v3_nxt;
      v6_r    <= v6_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
      best1_r <= best1_nxt;
      hour1_r <= hour1_nxt;
      best3_r <= best3_nxt;
      hour3_r <= hour3_nxt;
      best6_r <= best6_nxt;
      hour6_r <= hour6_nxt;
      last_r  <= last_nxt;
      pair_r  <= pair_nxt;
      for (int k = 0; k < 3; k++) begin
        hist_r[k] <= hist_nxt[k];
      end
    end
  end

  // findings stay zero until set, so the next state is the result directly
  always_comb begin
    res.min_price            = low_nxt;
    res.max_price            = high_nxt;
    res.have_price           = have_nxt;
    res.cheapest_hour        = hour1_nxt;
    res.cheapest_hour_valid  = v1_nxt;
    res.cheapest_three_start = hour3_nxt;
    res.cheapest_three_valid = v3_nxt;
    res.cheapest_six_start   = hour6_nxt;
    res.cheapest_six_valid   = v6_nxt;
  end

  `CPWF_ASSERT_NOW(a_flags_nested, v6_r || v3_r || v1_r, have_r && v1_r && (v3_r || !v6_r))
  `CPWF_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= cnt_t'(HOURS))
  `CPWF_ASSERT_NEXT(a_first_price, upd && item.first && !item.missing,
                    cnt_r == cnt_t'(1) && have_r && v1_r && hour1_r == '0)

endmodule
`default_nettype wire

>>> sv/cheapest_price_window_finder.sv
// Top level of the cheapest price window finder: input and result registers
//
//  channel | dir | payload                                         | handshake
//  in_ch   | in  | price, missing, first                           | valid/ready
//  out_ch  | out | min/max, have, cheapest hour, 3h and 6h starts  | valid/ready
//
// One item per cycle while out_ch is ready; out_ch is driven from the result register.
// The tracking state updates as an item moves from the input register to the result
// register, so each result reflects that item and all earlier items of its day.
// rst_n (synchronous) clears the day and the valid flags of both registers.
// out_ch stall holds the result; an empty input register still takes one more item.
`default_nettype none
`include "cheapest_price_window_finder_defines.svh"
module cheapest_price_window_finder (
  input wire logic clk,
  input wire logic rst_n,
  cpwf_in_if.sink    in_ch,
  cpwf_out_if.source out_ch
);
  import cpwf_pkg::*;

  item_t   in_r;
  logic    in_v_r;
  result_t out_r;
  logic    out_v_r;
  result_t res;
  logic    out_load;
  logic    in_take;

  assign out_load    = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || out_load;
  assign in_take     = in_ch.valid && in_ch.ready;

  cpwf_track u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (out_load),
    .item  (in_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_v_r <= 1'b1;
      end else if (out_load) begin
        in_v_r <= 1'b0;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r.price   <= in_ch.price;
      in_r.missing <= in_ch.missing;
      in_r.first   <= in_ch.first;
    end
    if (out_load) begin
      out_r <= res;
    end
  end

  assign out_ch.valid                = out_v_r;
  assign out_ch.min_price            = out_r.min_price;
  assign out_ch.max_price            = out_r.max_price;
  assign out_ch.have_price           = out_r.have_price;
  assign out_ch.cheapest_hour        = out_r.cheapest_hour;
  assign out_ch.cheapest_hour_valid  = out_r.cheapest_hour_valid;
  assign out_ch.cheapest_three_start = out_r.cheapest_three_start;
  assign out_ch.cheapest_three_valid = out_r.cheapest_three_valid;
  assign out_ch.cheapest_six_start   = out_r.cheapest_six_start;
  assign out_ch.cheapest_six_valid   = out_r.cheapest_six_valid;

  `CPWF_ASSERT_NOW(a_ready_when_drained, !out_v_r, in_ch.ready)
  `CPWF_ASSERT_NEXT(a_load_gives_result, out_load, out_v_r)
  `CPWF_ASSERT_NEXT(a_stall_keeps_item, in_v_r && out_v_r && !out_ch.ready, in_v_r)

endmodule
`default_nettype wire
